// ===== hdl/lrp_pkg.sv =====
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared widths, codes, reset values and types for the lidar range-to-point
// unit.
// ----------------------------------------------------------------------------
package lrp_pkg;

  localparam int TABLE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  localparam int IDX_W    = 16;
  localparam int RANGE_W  = 20;
  localparam int DIR_W    = 18;
  localparam int OFF_W    = 16;
  localparam int COEF_W   = 18;
  localparam int COL_W    = 3 * COEF_W;
  localparam int PT_W     = 26;

  localparam int DIR_RAM_W = 3 * DIR_W;
  localparam int OFF_RAM_W = 3 * OFF_W;

  // datapath widths
  localparam int OFF_SHIFT  = 12;                      // 1/16 mm -> 2^-16 mm
  localparam int V_W        = DIR_W + RANGE_W + 1;     // dir * range + offset
  localparam int PROD_W     = V_W + COEF_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int FRAC_SHIFT = 28;
  localparam int SH_W       = SUM_W - FRAC_SHIFT;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = COL_W;

  localparam logic [RANGE_W-1:0] RANGE_FLOOR = RANGE_W'(1);
  localparam logic [RANGE_W-1:0] RANGE_CEIL  = RANGE_W'(1000000);

  localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(65536);
  localparam logic [COL_W-1:0]  COL_X_RST = COL_W'(COEF_ONE);
  localparam logic [COL_W-1:0]  COL_Y_RST = COL_W'(COEF_ONE) << COEF_W;
  localparam logic [COL_W-1:0]  COL_Z_RST = COL_W'(COEF_ONE) << (2 * COEF_W);

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_CONVERT = 1'b1
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MIN_RANGE = 3'd0,
    REG_MAX_RANGE = 3'd1,
    REG_ROT_COL_X = 3'd2,
    REG_ROT_COL_Y = 3'd3,
    REG_ROT_COL_Z = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [RANGE_W-1:0]         lo;
    logic [RANGE_W-1:0]         hi;
    logic [2:0][COL_W-1:0]      cols;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               ok;
    logic [RANGE_W-1:0] range;
  } stage_t;

endpackage

// ===== hdl/lrp_ram.sv =====
// ----------------------------------------------------------------------------
// lrp_ram
// Generic single-write, single-read synchronous RAM with registered read
// data. Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module lrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/lrp_cfg.sv =====
// ----------------------------------------------------------------------------
// lrp_cfg
// Configuration registers: range limits and rotation matrix columns.
// Produces the clamped effective range limits.
// ----------------------------------------------------------------------------
module lrp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lrp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lrp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lrp_pkg::cfg_t                  cfg
);
  import lrp_pkg::*;

  logic [RANGE_W-1:0]    min_r, min_nxt;
  logic [RANGE_W-1:0]    max_r, max_nxt;
  logic [2:0][COL_W-1:0] cols_r, cols_nxt;

  always_comb begin
    min_nxt  = min_r;
    max_nxt  = max_r;
    cols_nxt = cols_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_MIN_RANGE: min_nxt     = cfg_wdata[RANGE_W-1:0];
        REG_MAX_RANGE: max_nxt     = cfg_wdata[RANGE_W-1:0];
        REG_ROT_COL_X: cols_nxt[0] = cfg_wdata[COL_W-1:0];
        REG_ROT_COL_Y: cols_nxt[1] = cfg_wdata[COL_W-1:0];
        REG_ROT_COL_Z: cols_nxt[2] = cfg_wdata[COL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r     <= RANGE_FLOOR;
      max_r     <= RANGE_CEIL;
      cols_r[0] <= COL_X_RST;
      cols_r[1] <= COL_Y_RST;
      cols_r[2] <= COL_Z_RST;
    end else begin
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      cols_r <= cols_nxt;
    end
  end

  always_comb begin
    cfg.lo   = (min_r < RANGE_FLOOR) ? RANGE_FLOOR : min_r;
    cfg.hi   = (max_r > RANGE_CEIL)  ? RANGE_CEIL  : max_r;
    cfg.cols = cols_r;
  end

endmodule

// ===== hdl/lrp_math.sv =====
// ----------------------------------------------------------------------------
// lrp_math
// Point datapath after the table read: scale and offset, rotation products,
// column sums with floor shift and saturation, output register.
// ----------------------------------------------------------------------------
module lrp_math (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  lrp_pkg::stage_t                     s1,
  input  logic [lrp_pkg::DIR_RAM_W-1:0]       dir_rd,
  input  logic [lrp_pkg::OFF_RAM_W-1:0]       off_rd,
  input  logic [2:0][lrp_pkg::COL_W-1:0]      cols,
  output logic                                out_valid,
  output logic signed [lrp_pkg::PT_W-1:0]     out_point_x,
  output logic signed [lrp_pkg::PT_W-1:0]     out_point_y,
  output logic signed [lrp_pkg::PT_W-1:0]     out_point_z,
  output logic [lrp_pkg::RANGE_W-1:0]         out_point_range_mm,
  output logic                                out_in_range
);
  import lrp_pkg::*;

  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((2 ** (PT_W - 1)) - 1);
  localparam logic signed [SH_W-1:0] SAT_LO = -SAT_HI - SH_W'(1);

  logic signed [DIR_W-1:0]   dir [3];
  logic signed [OFF_W-1:0]   off [3];
  logic signed [RANGE_W:0]   rng_s;
  logic signed [V_W-1:0]     mul [3];
  logic signed [COEF_W-1:0]  coef [3][3];
  logic signed [SUM_W-1:0]   sum [3];
  logic signed [SH_W-1:0]    sh [3];

  stage_t                    s2_r, s3_r;
  logic signed [V_W-1:0]     v_r [3], v_nxt [3];
  logic signed [PROD_W-1:0]  p_r [3][3], p_nxt [3][3];
  logic signed [PT_W-1:0]    pt_r [3], pt_nxt [3];
  logic [RANGE_W-1:0]        rng_r, rng_nxt;
  logic                      valid_r, inr_r, inr_nxt;

  // stage 2: v = dir * range + offset, in 2^-16 mm
  always_comb begin
    rng_s = $signed({1'b0, s1.range});
    for (int k = 0; k < 3; k++) begin
      dir[k]   = dir_rd[k*DIR_W +: DIR_W];
      off[k]   = off_rd[k*OFF_W +: OFF_W];
      mul[k]   = dir[k] * rng_s;
      v_nxt[k] = mul[k] + (V_W'(off[k]) <<< OFF_SHIFT);
    end
  end

  // stage 3: products with matrix columns
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        coef[j][k]  = cols[j][k*COEF_W +: COEF_W];
        p_nxt[j][k] = v_r[k] * coef[j][k];
      end
    end
  end

  // output stage: sum, floor shift, saturate; rejected beats give zero fields
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum[j] = SUM_W'(p_r[j][0]) + SUM_W'(p_r[j][1]) + SUM_W'(p_r[j][2]);
      sh[j]  = sum[j][SUM_W-1:FRAC_SHIFT];
      if (!s3_r.ok) begin
        pt_nxt[j] = '0;
      end else if (sh[j] > SAT_HI) begin
        pt_nxt[j] = SAT_HI[PT_W-1:0];
      end else if (sh[j] < SAT_LO) begin
        pt_nxt[j] = SAT_LO[PT_W-1:0];
      end else begin
        pt_nxt[j] = sh[j][PT_W-1:0];
      end
    end
    rng_nxt = s3_r.ok ? s3_r.range : '0;
    inr_nxt = s3_r.ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r    <= '0;
      s3_r    <= '0;
      valid_r <= 1'b0;
    end else if (adv) begin
      s2_r    <= s1;
      s3_r    <= s2_r;
      valid_r <= s3_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r   <= v_nxt;
      p_r   <= p_nxt;
      pt_r  <= pt_nxt;
      rng_r <= rng_nxt;
      inr_r <= inr_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_point_x        = pt_r[0];
  assign out_point_y        = pt_r[1];
  assign out_point_z        = pt_r[2];
  assign out_point_range_mm = rng_r;
  assign out_in_range       = inr_r;

endmodule

// ===== hdl/lidar_range_to_point_unit.sv =====
// ----------------------------------------------------------------------------
// lidar_range_to_point_unit
// Lidar range sample to rotated Cartesian point converter with per-pixel
// direction and offset tables.
// ----------------------------------------------------------------------------
// Takes one beat per cycle on the input channel while the output is not
// stalled, loads or conversions mixed freely. A load writes the direction and
// offset tables in the cycle it is accepted and gives no result. A conversion
// reads both tables through their single read port; its result passes through
// the table read at acceptance, then scale and offset, rotation products, sum
// with floor shift and saturation into the output register. A result waiting
// with out_ready low stalls every stage at once; in_ready follows the output
// register being free or taken. Tables come out of reset without contents
// and need no clearing; conversions before the first load are dropped.
module lidar_range_to_point_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic [lrp_pkg::IDX_W-1:0]           in_pixel_index,
  input  logic [lrp_pkg::RANGE_W-1:0]         in_range_mm,
  input  logic signed [lrp_pkg::DIR_W-1:0]    in_dir_x,
  input  logic signed [lrp_pkg::DIR_W-1:0]    in_dir_y,
  input  logic signed [lrp_pkg::DIR_W-1:0]    in_dir_z,
  input  logic signed [lrp_pkg::OFF_W-1:0]    in_off_x,
  input  logic signed [lrp_pkg::OFF_W-1:0]    in_off_y,
  input  logic signed [lrp_pkg::OFF_W-1:0]    in_off_z,
  input  logic                                cfg_we,
  input  logic [lrp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [lrp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lrp_pkg::PT_W-1:0]     out_point_x,
  output logic signed [lrp_pkg::PT_W-1:0]     out_point_y,
  output logic signed [lrp_pkg::PT_W-1:0]     out_point_z,
  output logic [lrp_pkg::RANGE_W-1:0]         out_point_range_mm,
  output logic                                out_in_range
);
  import lrp_pkg::*;

  cfg_t                 cfg;
  logic                 adv, accept, idx_ok, tab_we;
  logic [31:0]          idx_ext;
  logic [ADDR_W-1:0]    addr;
  logic [DIR_RAM_W-1:0] dir_rd;
  logic [OFF_RAM_W-1:0] off_rd;
  logic                 loaded_r, loaded_nxt;
  stage_t               s1_r, s1_nxt;

  lrp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  assign idx_ext = 32'(in_pixel_index);
  assign idx_ok  = idx_ext < 32'(TABLE_DEPTH);
  assign addr    = idx_ext[ADDR_W-1:0];
  assign tab_we  = accept && (in_op == OP_LOAD) && idx_ok;

  // Writes land at acceptance and reads issue at acceptance, one beat per
  // cycle while not stalled, so a read always sees every earlier load.
  lrp_ram #(.WIDTH(DIR_RAM_W), .DEPTH(TABLE_DEPTH)) u_dir_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (addr),
    .wdata ({in_dir_z, in_dir_y, in_dir_x}),
    .re    (adv),
    .raddr (addr),
    .rdata (dir_rd)
  );

  lrp_ram #(.WIDTH(OFF_RAM_W), .DEPTH(TABLE_DEPTH)) u_off_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (addr),
    .wdata ({in_off_z, in_off_y, in_off_x}),
    .re    (adv),
    .raddr (addr),
    .rdata (off_rd)
  );

  always_comb begin
    loaded_nxt = loaded_r || (accept && (in_op == OP_LOAD));
    s1_nxt     = s1_r;
    if (adv) begin
      s1_nxt.valid = accept && (in_op == OP_CONVERT) && loaded_r;
      s1_nxt.ok    = idx_ok && (in_range_mm >= cfg.lo) && (in_range_mm <= cfg.hi);
      s1_nxt.range = in_range_mm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= 1'b0;
      s1_r     <= '0;
    end else begin
      loaded_r <= loaded_nxt;
      s1_r     <= s1_nxt;
    end
  end

  lrp_math u_math (
    .clk                (clk),
    .rst_n              (rst_n),
    .adv                (adv),
    .s1                 (s1_r),
    .dir_rd             (dir_rd),
    .off_rd             (off_rd),
    .cols               (cfg.cols),
    .out_valid          (out_valid),
    .out_point_x        (out_point_x),
    .out_point_y        (out_point_y),
    .out_point_z        (out_point_z),
    .out_point_range_mm (out_point_range_mm),
    .out_in_range       (out_in_range)
  );

`ifndef SYNTH
  a_no_result_before_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> loaded_r)
    else $error("result beat without any table load");

  a_rejected_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |->
      (out_point_x == '0 && out_point_y == '0 && out_point_z == '0 &&
       out_point_range_mm == '0))
    else $error("rejected beat carries nonzero fields");

  a_accepted_range_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_range) |-> (out_point_range_mm != '0))
    else $error("accepted beat with zero range");

  a_load_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    tab_we |=> (loaded_r && !$past(out_valid && !out_ready)))
    else $error("table write while stalled or without load flag");
`endif

endmodule
